// File: src/cat_pkg.sv
// Package with the shared types, constants and functions of the card access table.
`timescale 1ns / 1ps
package cat_pkg;

  // Default table size and flush delay.
  localparam int unsigned SlotCountDef = 16;
  localparam logic [15:0] TimeoutDef   = 16'd5000;

  // Operation codes of an input transfer.
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CHECK  = 3'd2,
    OP_GET    = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  // Status codes of a result transfer.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EXISTS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;
    logic scan_last;
  } dp_sts_t;

  // Identifiers that the first three slots hold after reset.
  function automatic logic [31:0] init_id(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'h1234_5678;
      1:       val = 32'h8765_4321;
      2:       val = 32'hABCD_EF00;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

// File: src/cat_if.sv
// Valid/ready interfaces of the request and result channels.
`timescale 1ns / 1ps
interface cat_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] card_id;
  logic [31:0] now_time;

  modport source (output valid, output operation, output card_id, output now_time,
                  input ready);
  modport sink (input valid, input operation, input card_id, input now_time,
                output ready);
endinterface

interface cat_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] stamp;
  logic [4:0]  live_count;
  logic        flush_request;

  modport source (output valid, output status, output stamp, output live_count,
                  output flush_request, input ready);
  modport sink (input valid, input status, input stamp, input live_count,
                input flush_request, output ready);
endinterface

// File: src/cat_ctrl.sv
// Controller state machine that sequences capture, slot scan and commit.
`timescale 1ns / 1ps
module cat_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cat_pkg::dp_sts_t sts,
  output cat_pkg::dp_cmd_t cmd
);
  import cat_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.needs_scan) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // The last slot read is examined at the end of this cycle.
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A new result is loaded only when the output register is free or being emptied.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result loaded over a waiting result");
`endif

endmodule

// File: src/cat_dp.sv
// Datapath: slot storage, scan evaluation, flush countdown and result register.
`timescale 1ns / 1ps
module cat_dp #(
  parameter int unsigned SLOT_COUNT = cat_pkg::SlotCountDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cat_pkg::dp_cmd_t cmd,
  output cat_pkg::dp_sts_t sts,
  input  logic [2:0]       in_operation,
  input  logic [31:0]      in_card_id,
  input  logic [31:0]      in_now_time,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  output logic [1:0]       out_status,
  output logic [31:0]      out_stamp,
  output logic [4:0]       out_live_count,
  output logic             out_flush_request
);
  import cat_pkg::*;

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam logic [SW-1:0] LastIdx = SW'(SLOT_COUNT - 1);

  // Slot memories.
  logic [31:0] mem_id   [SLOT_COUNT];
  logic [31:0] mem_time [SLOT_COUNT];

  // Captured request and configuration.
  logic [2:0]  op_r;
  logic [31:0] id_r, now_r;
  logic [15:0] timeout_r;

  // Per-slot flags and table state.
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [SLOT_COUNT-1:0] written_r, written_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  pending_r, pending_nxt;
  logic [15:0]           cd_r, cd_nxt;

  // Scan pipeline.
  logic [SW-1:0] scan_addr_r;
  logic          rd_vld_r;
  logic [SW-1:0] rd_idx_r;
  logic [31:0]   rd_id_r, rd_time_r;
  logic          rd_written_r, rd_act_r;

  // Scan findings.
  logic          free_hit_r, act_hit_r, first_hit_r, first_act_r;
  logic [SW-1:0] free_idx_r, act_idx_r;
  logic [31:0]   first_time_r;

  // Result register.
  logic [1:0]  status_r;
  logic [31:0] stamp_r;
  logic [4:0]  acnt_r;
  logic        flush_r;

  // Commit decision signals.
  op_t         op;
  logic [31:0] slot_id, slot_time;
  logic        present, changed, flush_nxt;
  logic        wr_en;
  logic [SW-1:0] wr_idx;
  status_t     status_nxt;
  logic [31:0] stamp_nxt;
  logic [15:0] load_val;
  logic [CW-1:0] id_nz;

  assign op = op_t'(op_r);
  assign sts.needs_scan = (op == OP_ADD) || (op == OP_REMOVE) || (op == OP_CHECK) ||
                          (op == OP_GET);
  assign sts.scan_last = (scan_addr_r == LastIdx);

  // A slot never written reads as its reset contents.
  assign slot_id   = rd_written_r ? rd_id_r : init_id(32'(rd_idx_r));
  assign slot_time = rd_written_r ? rd_time_r : 32'd0;

  // Memory read during the scan and write at commit.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_id_r   <= mem_id[scan_addr_r];
      rd_time_r <= mem_time[scan_addr_r];
    end
    if (wr_en) begin
      mem_id[wr_idx]   <= id_r;
      mem_time[wr_idx] <= now_r;
    end
  end

  // Capture of the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      id_r  <= in_card_id;
      now_r <= in_now_time;
    end
  end

  // Scan address, read pipeline and findings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      free_hit_r  <= 1'b0;
      act_hit_r   <= 1'b0;
      first_hit_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;
      if (cmd.capture) begin
        scan_addr_r <= '0;
        free_hit_r  <= 1'b0;
        act_hit_r   <= 1'b0;
        first_hit_r <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_addr_r <= scan_addr_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (!free_hit_r && (slot_id == 32'd0 || !rd_act_r)) begin
            free_hit_r <= 1'b1;
          end
          if (!act_hit_r && slot_id == id_r && rd_act_r) begin
            act_hit_r <= 1'b1;
          end
          if (!first_hit_r && slot_id == id_r) begin
            first_hit_r <= 1'b1;
          end
        end
      end
    end
  end

  // Payload of the read pipeline and findings.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_idx_r     <= scan_addr_r;
      rd_written_r <= written_r[scan_addr_r];
      rd_act_r     <= active_r[scan_addr_r];
    end
    if (rd_vld_r) begin
      if (!free_hit_r && (slot_id == 32'd0 || !rd_act_r)) begin
        free_idx_r <= rd_idx_r;
      end
      if (!act_hit_r && slot_id == id_r && rd_act_r) begin
        act_idx_r <= rd_idx_r;
      end
      if (!first_hit_r && slot_id == id_r) begin
        first_act_r  <= rd_act_r;
        first_time_r <= slot_time;
      end
    end
  end

  // Outcome of the operation and next table state.
  always_comb begin
    present     = first_hit_r && (id_r != 32'd0);
    load_val    = (timeout_r == 16'd0) ? TimeoutDef : timeout_r;
    id_nz       = CW'(id_r != 32'd0);
    status_nxt  = ST_OK;
    stamp_nxt   = 32'd0;
    changed     = 1'b0;
    flush_nxt   = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = act_idx_r;
    active_nxt  = active_r;
    written_nxt = written_r;
    count_nxt   = count_r;
    pending_nxt = pending_r;
    cd_nxt      = cd_r;
    case (op)
      OP_ADD: begin
        wr_idx = free_idx_r;
        if (present) begin
          status_nxt = ST_EXISTS;
        end else if (!free_hit_r) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en                  = 1'b1;
          changed                = 1'b1;
          active_nxt[free_idx_r] = 1'b1;
          count_nxt              = count_r + id_nz;
        end
      end
      OP_REMOVE: begin
        if (act_hit_r) begin
          changed               = 1'b1;
          active_nxt[act_idx_r] = 1'b0;
          count_nxt             = count_r - id_nz;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_CHECK: begin
        if (act_hit_r) begin
          wr_en = 1'b1;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_GET: begin
        if (first_hit_r && first_act_r) begin
          stamp_nxt = first_time_r;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_TICK: begin
        if (cd_r != 16'd0) begin
          cd_nxt = cd_r - 16'd1;
          if (cd_r == 16'd1 && pending_r) begin
            pending_nxt = 1'b0;
            flush_nxt   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (changed) begin
      pending_nxt = 1'b1;
      cd_nxt      = load_val;
    end
    if (wr_en) begin
      written_nxt[wr_idx] = 1'b1;
    end
    wr_en = wr_en && cmd.commit;
  end

  // Table control state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= SLOT_COUNT'(3'b111);
      written_r <= '0;
      count_r   <= CW'(3);
      pending_r <= 1'b0;
      cd_r      <= 16'd0;
      timeout_r <= TimeoutDef;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        active_r  <= active_nxt;
        written_r <= written_nxt;
        count_r   <= count_nxt;
        pending_r <= pending_nxt;
        cd_r      <= cd_nxt;
      end
    end
  end

  // Result register, with the active count saturated to the field width.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      stamp_r  <= stamp_nxt;
      acnt_r   <= (32'(count_nxt) > 32'd31) ? 5'd31 : 5'(count_nxt);
      flush_r  <= flush_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_stamp         = stamp_r;
  assign out_live_count    = acnt_r;
  assign out_flush_request = flush_r;

`ifndef SYNTHESIS
  // Counted slots are always a subset of the active slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'($countones(active_r)))
    else $error("active count exceeds active marks");

  // A pending write always has a running countdown.
  a_pending_cd: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (cd_r != 16'd0))
    else $error("pending write without running countdown");
`endif

endmodule

// File: src/card_access_table.sv
// Top level of the card access table.
//
// Requests arrive on in_req (operation, card_id, now_time) with valid/ready;
// a transfer takes place when both are high at a rising clock edge. Each
// request gives exactly one result transfer on out_rsp (status, stamp,
// live_count, flush_request), in order. cfg_wr_en with cfg_wr_data writes
// the flush delay in ticks; write it only while the block is idle.
// Add, remove, check and get read the slots one per cycle through a single
// memory read port; a tick or an unused code skips the scan. A new request
// is taken in the cycle after its predecessor's result is loaded, so
// requests are worked on one at a time. The result register holds a
// finished result while out_rsp is stalled; the next request is still
// taken and worked on, and its result waits until the register is
// emptied.
// Synchronous reset (rst_n low) restores the three default cards as active,
// clears the dirty mark and countdown and sets the delay to 5000 ticks. It
// takes effect at once: no clearing pass runs.
`timescale 1ns / 1ps
module card_access_table #(
  parameter int unsigned SLOT_COUNT = cat_pkg::SlotCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  cat_req_if.sink     in_req,
  cat_rsp_if.source   out_rsp,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import cat_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing of each request.
  cat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table storage and result computation.
  cat_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_req.operation),
    .in_card_id        (in_req.card_id),
    .in_now_time       (in_req.now_time),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_status        (out_rsp.status),
    .out_stamp         (out_rsp.stamp),
    .out_live_count    (out_rsp.live_count),
    .out_flush_request (out_rsp.flush_request)
  );

endmodule
